>>> src/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants of the button press classifier
// Holds the payload structs of both channels, the register reset value and
// the default sizes of the button set and of the event queue.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int BUTTON_BITS_W   = 3;
    localparam int NOW_W           = 32;
    localparam int THRESH_W        = 16;
    localparam int BUTTON_ID_W     = 2;

    localparam int NUM_BUTTONS_DEF = 3;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [THRESH_W-1:0] LONG_PRESS_RESET = 16'd2000;

    localparam logic KIND_SHORT = 1'b0;
    localparam logic KIND_LONG  = 1'b1;

    typedef struct packed {
        logic [BUTTON_BITS_W-1:0] button_bits;
        logic [NOW_W-1:0]         now_ms;
    } t_in_item;

    typedef struct packed {
        logic [BUTTON_ID_W-1:0] button_id;
        logic                   press_kind;
        logic                   last;
    } t_out_item;

endpackage

>>> src/bpc_front.sv
// ----------------------------------------------------------------------------
// bpc_front: per-button press tracking
// Takes one sample per cycle while accepted, updates the pressed, reported
// and press time state of every button at once and hands the event set on.
// ----------------------------------------------------------------------------
module bpc_front #(
    parameter int NUM_BUTTONS = 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  bpc_pkg::t_in_item            i_item,
    input  logic [bpc_pkg::THRESH_W-1:0] i_thresh,
    output logic                         o_push,
    output logic [2*NUM_BUTTONS-1:0]     o_entry
);
    import bpc_pkg::*;

    logic [NUM_BUTTONS-1:0] r_pressed;
    logic [NUM_BUTTONS-1:0] r_reported;
    logic [NOW_W-1:0]       r_press_time [NUM_BUTTONS];

    logic [NUM_BUTTONS-1:0] n_pressed;
    logic [NUM_BUTTONS-1:0] n_reported;
    logic [NUM_BUTTONS-1:0] level;
    logic [NUM_BUTTONS-1:0] evt_mask;
    logic [NUM_BUTTONS-1:0] evt_kind;
    logic [NOW_W-1:0]       held [NUM_BUTTONS];

    always_comb begin
        n_pressed  = r_pressed;
        n_reported = r_reported;
        evt_mask   = '0;
        evt_kind   = '0;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            // Lines beyond the sampled button bits always read as released.
            level[i] = (i < BUTTON_BITS_W) ? i_item.button_bits[i % BUTTON_BITS_W] : 1'b0;
            held[i]  = i_item.now_ms - r_press_time[i];
            if (r_pressed[i] == level[i]) begin
                if (level[i] && !r_reported[i]
                        && (held[i] > {{(NOW_W-THRESH_W){1'b0}}, i_thresh})) begin
                    evt_mask[i]   = 1'b1;
                    evt_kind[i]   = KIND_LONG;
                    n_reported[i] = 1'b1;
                end
            end else begin
                n_pressed[i] = level[i];
                if (level[i]) begin
                    n_reported[i] = 1'b0;
                end else if (held[i] < {{(NOW_W-THRESH_W){1'b0}}, i_thresh}) begin
                    evt_mask[i] = 1'b1;
                    evt_kind[i] = KIND_SHORT;
                end
            end
        end
    end

    assign o_push  = i_accept && (evt_mask != '0);
    assign o_entry = {evt_kind, evt_mask};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed  <= '0;
            r_reported <= '0;
        end else if (i_accept) begin
            r_pressed  <= n_pressed;
            r_reported <= n_reported;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (i_accept && level[i] && !r_pressed[i]) begin
                r_press_time[i] <= i_item.now_ms;
            end
        end
    end

endmodule

>>> src/bpc_queue.sv
// ----------------------------------------------------------------------------
// bpc_queue: small event set queue
// Register-based FIFO that decouples the sample side from the event side.
// ----------------------------------------------------------------------------
module bpc_queue #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_full,
    output logic [WIDTH-1:0] o_data
);
    import bpc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> src/bpc_back.sv
// ----------------------------------------------------------------------------
// bpc_back: event serializer
// Takes one event set from the queue and, while the output is not stalled,
// sends its events one per cycle in button order, marking the final one.
// ----------------------------------------------------------------------------
module bpc_back #(
    parameter int NUM_BUTTONS = 3
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_q_valid,
    input  logic [2*NUM_BUTTONS-1:0] i_q_data,
    output logic                     o_q_pop,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output bpc_pkg::t_out_item       o_out_data
);
    import bpc_pkg::*;

    logic [NUM_BUTTONS-1:0] r_mask;
    logic [NUM_BUTTONS-1:0] r_kind;
    logic                   r_out_valid;
    t_out_item              r_out_data;

    logic [NUM_BUTTONS-1:0] sel;
    logic [NUM_BUTTONS-1:0] mask_after;
    logic [NUM_BUTTONS-1:0] n_mask;
    logic                   emit;
    logic                   found;
    t_out_item              n_out_data;

    always_comb begin
        sel        = '0;
        found      = 1'b0;
        n_out_data = '0;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (r_mask[i] && !found) begin
                found                 = 1'b1;
                sel[i]                = 1'b1;
                n_out_data.button_id  = BUTTON_ID_W'(i);
                n_out_data.press_kind = r_kind[i];
            end
        end
        n_out_data.last = ((r_mask & ~sel) == '0);
    end

    assign emit       = (r_mask != '0) && (!r_out_valid || i_out_ready);
    assign mask_after = emit ? (r_mask & ~sel) : r_mask;
    // The next set is loaded in the same cycle the current one runs dry.
    assign o_q_pop    = i_q_valid && (mask_after == '0);
    assign n_mask     = o_q_pop ? i_q_data[NUM_BUTTONS-1:0] : mask_after;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mask <= n_mask;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_kind <= i_q_data[2*NUM_BUTTONS-1:NUM_BUTTONS];
        end
        if (emit) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> src/button_press_classifier.sv
// With an idle back end the first event of a sample reaches the output
// through the queue, the back end's set mask register and its output register.
// Throughput: one sample per cycle while the event queue has room; events
// leave one per cycle while the output is not stalled.
// The output event rate is set by the single-event output register.
// Reset (synchronous, active low) releases all buttons, empties the queue and
// restores the long press threshold to 2000 ms.
// ----------------------------------------------------------------------------
// button_press_classifier: short and long button press detector
// Classifies timestamped button samples into short and long press events.
// ----------------------------------------------------------------------------
module button_press_classifier #(
    parameter int NUM_BUTTONS = bpc_pkg::NUM_BUTTONS_DEF,
    parameter int QUEUE_DEPTH = bpc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bpc_pkg::THRESH_W-1:0] i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  bpc_pkg::t_in_item            i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output bpc_pkg::t_out_item           o_out_data
);
    import bpc_pkg::*;

    logic [THRESH_W-1:0]      r_thresh;
    logic                     accept;
    logic                     push;
    logic                     pop;
    logic                     q_valid;
    logic                     q_full;
    logic [2*NUM_BUTTONS-1:0] push_entry;
    logic [2*NUM_BUTTONS-1:0] q_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= LONG_PRESS_RESET;
        end else if (i_cfg_we) begin
            r_thresh <= i_cfg_data;
        end
    end

    assign o_in_ready = !q_full;
    assign accept     = i_in_valid && o_in_ready;

    bpc_front #(
        .NUM_BUTTONS(NUM_BUTTONS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_data),
        .i_thresh (r_thresh),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    bpc_queue #(
        .WIDTH(2 * NUM_BUTTONS),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (q_entry)
    );

    bpc_back #(
        .NUM_BUTTONS(NUM_BUTTONS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_entry),
        .o_q_pop     (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

>>> src/bpc_checker.sv
// ----------------------------------------------------------------------------
// bpc_checker: port-level checks of the button press classifier
// Watches the output channel and reset behavior at the top-level ports.
// ----------------------------------------------------------------------------
module bpc_checker #(
    parameter int NUM_BUTTONS = 3
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input bpc_pkg::t_out_item o_out_data
);
    import bpc_pkg::*;

    // A pending output transaction is not withdrawn.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output transaction dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("output payload changed while stalled");

    a_id_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (NUM_BUTTONS > 3) || (o_out_data.button_id != 2'd3))
        else $error("button id out of range");

    // Right after reset no event is pending and the queue has room.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not idle after reset");

endmodule

bind button_press_classifier bpc_checker #(
    .NUM_BUTTONS(NUM_BUTTONS)
) u_bpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

>>> tb/button_press_classifier_tb.sv
// ----------------------------------------------------------------------------
// button_press_classifier_tb: self-checking bench for the press classifier
// Feeds timestamped button samples through the valid/ready input channel,
// predicts the short and long press events of every accepted sample and
// compares each event leaving the output channel with the oldest prediction.
// Several thresholds are exercised, among them the smallest and largest.
// ----------------------------------------------------------------------------
module button_press_classifier_tb;

    import bpc_pkg::*;

    localparam int NUM_BTN        = NUM_BUTTONS_DEF;
    localparam int DRAIN_CYCLES   = 10;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int MAX_REPORTS    = 10;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic [THRESH_W-1:0] i_cfg_data  = '0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    t_in_item            i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_out_item           o_out_data;

    button_press_classifier DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Samples waiting to be driven and press events waiting to be seen.
    t_in_item  samples_to_send[$];
    t_out_item pending_events[$];

    int send_idle_pct  = 17;
    int recv_stall_pct = 66;

    // Predicted state of the buttons and the threshold.
    logic [THRESH_W-1:0] press_threshold = LONG_PRESS_RESET;
    logic                btn_down[NUM_BTN];
    logic                long_sent[NUM_BTN];
    logic [NOW_W-1:0]    down_since[NUM_BTN];

    // State of the sample generator, kept apart from the prediction.
    logic [BUTTON_BITS_W-1:0] gen_level = '0;
    logic [NOW_W-1:0]         gen_since[NUM_BTN];
    logic [NOW_W-1:0]         gen_now   = '0;
    int unsigned              gen_thr   = LONG_PRESS_RESET;

    int mismatches     = 0;
    int samples_sent   = 0;
    int longs_checked  = 0;
    int shorts_checked = 0;
    int thresholds_run = 1;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_CYCLES * 10);
        $display("Timeout with %0d samples queued and %0d events outstanding",
                 samples_to_send.size(), pending_events.size());
        $display("Verification failed");
        $finish;
    end

    // Works out the events of one sample and advances the predicted state.
    function automatic void classify_sample(input t_in_item s);
        t_out_item        found[NUM_BTN];
        int               n;
        logic             level;
        logic [NOW_W-1:0] held;
        n = 0;
        for (int b = 0; b < NUM_BTN; b++) begin
            level = s.button_bits[b];
            held  = s.now_ms - down_since[b];
            if (btn_down[b] == level) begin
                if (level && !long_sent[b] && held > NOW_W'(press_threshold)) begin
                    found[n] = '{button_id: BUTTON_ID_W'(b), press_kind: KIND_LONG,
                                 last: 1'b0};
                    n++;
                    long_sent[b] = 1'b1;
                end
            end else begin
                btn_down[b] = level;
                if (level) begin
                    down_since[b] = s.now_ms;
                    long_sent[b]  = 1'b0;
                end else if (held < NOW_W'(press_threshold)) begin
                    found[n] = '{button_id: BUTTON_ID_W'(b), press_kind: KIND_SHORT,
                                 last: 1'b0};
                    n++;
                end
            end
        end
        for (int k = 0; k < n; k++) begin
            found[k].last = (k == n - 1);
            pending_events.insert(pending_events.size(), found[k]);
        end
    endfunction

    function automatic void check_event(input t_out_item got);
        t_out_item want;
        if (pending_events.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("Unexpected event: id %0d kind %0d last %0d",
                         got.button_id, got.press_kind, got.last);
        end else begin
            want = pending_events.pop_front();
            if (got.button_id !== want.button_id || got.press_kind !== want.press_kind ||
                    got.last !== want.last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Event mismatch: expected id %0d kind %0d last %0d, got %0d %0d %0d",
                             want.button_id, want.press_kind, want.last,
                             got.button_id, got.press_kind, got.last);
            end
            if (want.press_kind == KIND_LONG)
                longs_checked++;
            else
                shorts_checked++;
        end
    endfunction

    // Input driver: predicts each transaction as it is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                classify_sample(i_in_data);
                samples_sent++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (samples_to_send.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_in_data  <= samples_to_send.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor with random back pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready)
                check_event(o_out_data);
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    function automatic void queue_sample(input logic [BUTTON_BITS_W-1:0] bits,
                                         input logic [NOW_W-1:0] now);
        t_in_item s;
        s.button_bits = bits;
        s.now_ms      = now;
        samples_to_send.insert(samples_to_send.size(), s);
    endfunction

    // Mostly single-button presses and releases, with hold times aimed at
    // the threshold edges and now and then a jump anywhere in time.
    function automatic void queue_random_sample();
        logic [BUTTON_BITS_W-1:0] bits;
        int                       b;
        int                       pick;
        bits = gen_level;
        b    = $urandom_range(0, NUM_BTN - 1);
        pick = $urandom_range(0, 9);
        if (pick < 6)
            bits[b] = ~bits[b];
        else if (pick < 8)
            bits = BUTTON_BITS_W'($urandom_range(0, 7));
        case ($urandom_range(0, 9))
            0, 1, 2, 3: gen_now += $urandom_range(0, gen_thr / 4 + 1);
            4, 5: begin
                if (gen_level[b])
                    gen_now = gen_since[b] + gen_thr + $urandom_range(0, 2) - 1;
                else
                    gen_now += $urandom_range(0, gen_thr + 1);
            end
            6: gen_now += gen_thr + $urandom_range(0, 3);
            7: gen_now += $urandom_range(0, 2 * gen_thr + 2);
            8: gen_now = $urandom;
            default: ;
        endcase
        for (int i = 0; i < NUM_BTN; i++)
            if (bits[i] && !gen_level[i])
                gen_since[i] = gen_now;
        gen_level = bits;
        queue_sample(bits, gen_now);
    endfunction

    // Returns once nothing is queued, in flight or expected.
    task automatic wait_drained();
        do
            @(posedge i_clk);
        while (samples_to_send.size() != 0 || i_in_valid || pending_events.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [THRESH_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we        <= 1'b0;
        press_threshold  = value;
        gen_thr          = value;
        thresholds_run++;
    endtask

    task automatic run_random(input int count);
        repeat (count) queue_random_sample();
    endtask

    initial begin
        for (int b = 0; b < NUM_BTN; b++) begin
            btn_down[b]   = 1'b0;
            long_sent[b]  = 1'b0;
            down_since[b] = '0;
            gen_since[b]  = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed samples at the reset threshold of 2000 ms.
        queue_sample(3'b000, 32'd0);
        queue_sample(3'b111, 32'd100);
        queue_sample(3'b111, 32'd2100);         // held exactly the threshold
        queue_sample(3'b111, 32'd2101);         // one past: three long events
        queue_sample(3'b111, 32'd2200);         // already reported
        queue_sample(3'b000, 32'd2300);         // late release stays silent
        queue_sample(3'b001, 32'd5000);
        queue_sample(3'b000, 32'd6999);         // short on button 0
        queue_sample(3'b010, 32'd8000);
        queue_sample(3'b000, 32'd10000);        // release exactly at threshold
        queue_sample(3'b100, 32'hFFFF_FF00);
        queue_sample(3'b000, 32'h0000_0010);    // hold spans the time wrap
        queue_sample(3'b111, 32'h0002_0000);
        queue_sample(3'b000, 32'h0002_0005);    // three short events
        queue_sample(3'b001, 32'h0003_0000);
        queue_sample(3'b011, 32'h0003_05DC);
        queue_sample(3'b001, 32'h0003_07DB);    // long on button 0, short on button 1
        queue_sample(3'b101, 32'h0003_0800);
        queue_sample(3'b111, 32'hFFFF_FFFF);
        queue_sample(3'b000, 32'h0000_0100);
        wait_drained();

        // A threshold of one; the sender rests once in the middle.
        write_threshold(16'd1);
        run_random(17);
        wait_drained();
        run_random(18);
        wait_drained();

        send_idle_pct  = 66;
        recv_stall_pct = 17;
        write_threshold(16'hFFFF);
        run_random(35);
        wait_drained();

        // A zero threshold reports any hold and never gives a short press.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_threshold(16'd0);
        run_random(10);
        wait_drained();

        write_threshold(THRESH_W'($urandom_range(1, 65535)));
        run_random(20);
        wait_drained();

        $display("Covered %0d samples over %0d thresholds: %0d long and %0d short presses",
                 samples_sent, thresholds_run, longs_checked, shorts_checked);
        $display("Mismatching or unexpected events: %0d", mismatches);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
src/bpc_pkg.sv
src/bpc_front.sv
src/bpc_queue.sv
src/bpc_back.sv
src/button_press_classifier.sv
src/bpc_checker.sv
tb/button_press_classifier_tb.sv
